### rtl/slpc_pkg.sv
// ----------------------------------------------------------------------------
// slpc_pkg - shared types and constants of the sprite line pixel composer
// Holds the opcode codes, tile store sizes, the controller state type and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package slpc_pkg;

  localparam int TILES_PER_LINE = 34;
  localparam int CNT_W  = $clog2(TILES_PER_LINE + 1);
  localparam int IDX_W  = (TILES_PER_LINE > 1) ? $clog2(TILES_PER_LINE) : 1;
  localparam int ADDR_W = $clog2(2 * TILES_PER_LINE);
  localparam int DEPTH  = 2 * TILES_PER_LINE;

  typedef enum logic [1:0] {
    OP_NEW_LINE = 2'd0,
    OP_APPEND   = 2'd1,
    OP_PIXEL    = 2'd2,
    OP_FRAME    = 2'd3
  } opcode_t;

  localparam logic [2:0] REG_MAIN_EN = 3'd0;
  localparam logic [2:0] REG_SUB_EN  = 3'd1;
  localparam logic [2:0] REG_PRIO0   = 3'd2;
  localparam logic [2:0] REG_PRIO1   = 3'd3;
  localparam logic [2:0] REG_PRIO2   = 3'd4;
  localparam logic [2:0] REG_PRIO3   = 3'd5;

  typedef struct packed {
    logic [8:0]  xpos;
    logic [2:0]  pal;
    logic [1:0]  cls;
    logic        mirror;
    logic [31:0] planes;
  } tile_entry_t;

  typedef struct packed {
    logic            main_en;
    logic            sub_en;
    logic [3:0][3:0] prio;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_pixel;
    logic scan_empty;
    logic issue_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/slpc_ctrl.sv
// ----------------------------------------------------------------------------
// slpc_ctrl - controller of the sprite line pixel composer
// Sequences one request at a time: capture, scan and drain (pixel), finish.
// ----------------------------------------------------------------------------
module slpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  slpc_pkg::dp_status_t status,
  output slpc_pkg::ctrl_cmd_t  cmd
);
  import slpc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.req_pixel && !status.scan_empty) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (status.issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/slpc_dpath.sv
// ----------------------------------------------------------------------------
// slpc_dpath - datapath of the sprite line pixel composer
// Two-bank tile store memory, fill and scan counts, the per-tile pixel decode
// with its winner register, the line state and the output register.
// ----------------------------------------------------------------------------
module slpc_dpath (
  input  logic                clk,
  input  logic                rst,
  input  slpc_pkg::ctrl_cmd_t  cmd,
  output slpc_pkg::dp_status_t status,
  input  slpc_pkg::cfg_t       cfg,
  input  logic [1:0]          opcode,
  input  logic [8:0]          tile_xpos,
  input  logic [2:0]          tile_pal,
  input  logic [1:0]          tile_prio,
  input  logic                tile_hmirror,
  input  logic [31:0]         tile_planes,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          main_palette,
  output logic [3:0]          main_priority,
  output logic [7:0]          sub_palette,
  output logic [3:0]          sub_priority,
  output logic                time_over
);
  import slpc_pkg::*;

  // Tile store memory and its registered read port.
  tile_entry_t mem [DEPTH];
  tile_entry_t rd_data;
  logic        rd_valid;

  // Captured request.
  opcode_t     item_op;
  tile_entry_t item;

  // Line state.
  logic             fill_bank;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] scan_count;
  logic [8:0]       pixel_counter;
  logic             overflow_flag;
  logic [7:0]       main_pal_hold;
  logic [7:0]       sub_pal_hold;

  // Scan index and winner of the current pixel.
  logic [IDX_W-1:0] idx;
  logic             win_found;
  logic [7:0]       win_pal;
  logic [1:0]       win_cls;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;

  always_comb begin
    rd_addr = fill_bank ? ADDR_W'(idx) : ADDR_W'(TILES_PER_LINE) + ADDR_W'(idx);
    wr_addr = fill_bank ? ADDR_W'(TILES_PER_LINE) + ADDR_W'(fill_count)
                        : ADDR_W'(fill_count);
    wr_en   = cmd.finish && (item_op == OP_APPEND) &&
              (fill_count < CNT_W'(TILES_PER_LINE));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item;
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Pixel decode of the tile just read.
  logic signed [10:0] dot_delta;
  logic [2:0]         col;
  logic [2:0]         sh;
  logic [3:0]         colour;
  logic               hit;

  always_comb begin
    dot_delta = $signed({2'b00, pixel_counter}) -
                $signed({{2{rd_data.xpos[8]}}, rd_data.xpos});
    col    = dot_delta[2:0];
    sh     = rd_data.mirror ? col : 3'd7 - col;
    colour = {rd_data.planes[{2'd3, sh}], rd_data.planes[{2'd2, sh}],
              rd_data.planes[{2'd1, sh}], rd_data.planes[{2'd0, sh}]};
    hit    = (dot_delta[10:3] == 8'd0) && (colour != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op     <= opcode_t'(opcode);
      item.xpos   <= tile_xpos;
      item.pal    <= tile_pal;
      item.cls    <= tile_prio;
      item.mirror <= tile_hmirror;
      item.planes <= tile_planes;
      idx         <= '0;
      win_found   <= 1'b0;
    end else begin
      if (cmd.issue) begin
        idx <= idx + IDX_W'(1);
      end
      if (rd_valid && hit) begin
        win_found <= 1'b1;
        win_pal   <= {1'b1, rd_data.pal, colour};
        win_cls   <= rd_data.cls;
      end
    end
  end

  // Effects of the request at finish, and the result it produces.
  logic [7:0] main_pal_next;
  logic [7:0] sub_pal_next;
  logic [3:0] main_pr;
  logic [3:0] sub_pr;
  logic       overflow_next;

  always_comb begin
    main_pal_next = main_pal_hold;
    sub_pal_next  = sub_pal_hold;
    main_pr       = 4'd0;
    sub_pr        = 4'd0;
    overflow_next = overflow_flag;
    case (item_op)
      OP_APPEND: begin
        if (fill_count >= CNT_W'(TILES_PER_LINE)) begin
          overflow_next = 1'b1;
        end
      end
      OP_PIXEL: begin
        if (win_found && cfg.main_en) begin
          main_pal_next = win_pal;
          main_pr       = cfg.prio[win_cls];
        end
        if (win_found && cfg.sub_en) begin
          sub_pal_next = win_pal;
          sub_pr       = cfg.prio[win_cls];
        end
      end
      OP_FRAME: begin
        overflow_next = 1'b0;
      end
      default: begin
        overflow_next = overflow_flag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_bank     <= 1'b0;
      fill_count    <= '0;
      scan_count    <= '0;
      pixel_counter <= '0;
      overflow_flag <= 1'b0;
      main_pal_hold <= '0;
      sub_pal_hold  <= '0;
    end else if (cmd.finish) begin
      overflow_flag <= overflow_next;
      main_pal_hold <= main_pal_next;
      sub_pal_hold  <= sub_pal_next;
      case (item_op)
        OP_NEW_LINE: begin
          fill_bank     <= ~fill_bank;
          scan_count    <= fill_count;
          fill_count    <= '0;
          pixel_counter <= '0;
        end
        OP_APPEND: begin
          if (wr_en) begin
            fill_count <= fill_count + CNT_W'(1);
          end
        end
        OP_PIXEL: begin
          pixel_counter <= pixel_counter + 9'd1;
        end
        default: begin
          fill_count <= fill_count;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      main_palette  <= main_pal_next;
      main_priority <= main_pr;
      sub_palette   <= sub_pal_next;
      sub_priority  <= sub_pr;
      time_over     <= overflow_next;
    end
  end

  always_comb begin
    status.req_pixel  = (opcode_t'(opcode) == OP_PIXEL);
    status.scan_empty = (scan_count == '0);
    status.issue_last = ((CNT_W'(idx) + CNT_W'(1)) == scan_count);
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

### rtl/sprite_line_pixel_composer_top.sv
// ----------------------------------------------------------------------------
// sprite_line_pixel_composer_top - sprite line store and pixel composer
// Double-buffered sprite tile line store with per-pixel composition onto the
// main and sub screens, configured through an APB-style register port.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   -------   -------------------   ------------------------------------------
//   request   in_valid / in_stall   opcode, tile_xpos, tile_pal, tile_prio,
//                                   tile_hmirror, tile_planes
//   result    out_valid/out_stall   main_palette, main_priority, sub_palette,
//                                   sub_priority, time_over
//   config    APB psel/penable      paddr, pwdata, prdata, pready (always 1)
//
// A new line, append or frame request passes from idle straight to finish.
// A pixel request passes through scan, drain and finish when the scanned bank
// holds tiles (straight to finish when it is empty); the scan reads the bank
// through the single read port of the tile store, one tile per cycle.
// Reset leaves the tile store contents alone: per-bank fill counts mark which
// entries are valid, so no clearing pass is needed.
// A request is taken while the previous result still waits in the output
// register; a stalled result only delays the finish of the following request.
//
module sprite_line_pixel_composer_top (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [8:0]  tile_xpos,
  input  logic [2:0]  tile_pal,
  input  logic [1:0]  tile_prio,
  input  logic        tile_hmirror,
  input  logic [31:0] tile_planes,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  main_palette,
  output logic [3:0]  main_priority,
  output logic [7:0]  sub_palette,
  output logic [3:0]  sub_priority,
  output logic        time_over,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slpc_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register writes complete in the access phase; the register index is the
  // word address, and indexes past the last register are ignored.
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAIN_EN: cfg.main_en <= pwdata[0];
        REG_SUB_EN:  cfg.sub_en  <= pwdata[0];
        REG_PRIO0:   cfg.prio[0] <= pwdata[3:0];
        REG_PRIO1:   cfg.prio[1] <= pwdata[3:0];
        REG_PRIO2:   cfg.prio[2] <= pwdata[3:0];
        REG_PRIO3:   cfg.prio[3] <= pwdata[3:0];
        default:     cfg         <= cfg;
      endcase
    end
  end

  // Reads return the register value zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_MAIN_EN: prdata = {31'd0, cfg.main_en};
      REG_SUB_EN:  prdata = {31'd0, cfg.sub_en};
      REG_PRIO0:   prdata = {28'd0, cfg.prio[0]};
      REG_PRIO1:   prdata = {28'd0, cfg.prio[1]};
      REG_PRIO2:   prdata = {28'd0, cfg.prio[2]};
      REG_PRIO3:   prdata = {28'd0, cfg.prio[3]};
      default:     prdata = 32'd0;
    endcase
  end

  // The controller sequences each request; the datapath holds the store,
  // the scan and the result register.
  slpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  slpc_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .opcode        (opcode),
    .tile_xpos     (tile_xpos),
    .tile_pal      (tile_pal),
    .tile_prio     (tile_prio),
    .tile_hmirror  (tile_hmirror),
    .tile_planes   (tile_planes),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .main_palette  (main_palette),
    .main_priority (main_priority),
    .sub_palette   (sub_palette),
    .sub_priority  (sub_priority),
    .time_over     (time_over)
  );

  // Requests are handled one at a time, so two can never be taken in a row.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while the previous one is still in work");

  // A sprite pixel only reaches a screen that is enabled.
  a_main_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (main_priority != 4'd0)) |-> cfg.main_en)
    else $error("main screen priority set while main screen is disabled");

  a_sub_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (sub_priority != 4'd0)) |-> cfg.sub_en)
    else $error("sub screen priority set while sub screen is disabled");

endmodule
